### sv/pls_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the positional list store.
// Used by pls_ctrl, pls_cell, positional_list_store, list_result_checker and tb; depends on nothing.

package pls_pkg;

    localparam int FUNC_W   = 3;
    localparam int POS_W    = 5;
    localparam int PAYLD_W  = 32;
    localparam int RDATA_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int SLOT_W   = 8;
    localparam int IN_W     = FUNC_W + POS_W + PAYLD_W;

    typedef enum logic [FUNC_W-1:0] {
        OP_INSERT_AT    = 3'd0,
        OP_INSERT_FRONT = 3'd1,
        OP_INSERT_BACK  = 3'd2,
        OP_READ         = 3'd3,
        OP_REMOVE       = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic              ins;
        logic              rem;
        logic [SLOT_W-1:0] slot;
    } cell_cmd_t;

    typedef struct packed {
        logic [COUNT_W-1:0] entry_count;
        logic               empty_flag;
        status_t            status;
        logic [RDATA_W-1:0] read_data;
    } result_t;

    localparam int OUT_W = $bits(result_t);

endpackage

### sv/pls_ctrl.sv
`timescale 1ns / 1ps
// Request decoder for the positional list store: range and full checks,
// the shift command broadcast to the cells, and the next entry count.
// Depends on pls_pkg.

module pls_ctrl
    import pls_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int LEN_W    = 5
) (
    input  logic             req_valid,
    input  logic [FUNC_W-1:0] func,
    input  logic [POS_W-1:0] position,
    input  logic [LEN_W-1:0] length,
    output cell_cmd_t        cmd,
    output status_t          status,
    output logic             read_hit,
    output logic [LEN_W-1:0] length_next
);

    localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] len_ext;
    logic             full;
    logic             pos_past_end;
    logic             pos_at_or_past_end;

    assign pos_ext            = CMP_W'(position);
    assign len_ext            = CMP_W'(length);
    assign full               = (length == LEN_W'(CAPACITY));
    assign pos_past_end       = (pos_ext > len_ext);
    assign pos_at_or_past_end = (pos_ext >= len_ext);

    always_comb begin
        cmd      = '0;
        status   = ST_OK;
        read_hit = 1'b0;
        unique case (func_t'(func))
            OP_INSERT_AT: begin
                if (pos_past_end) begin
                    status = ST_RANGE;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    cmd.ins  = req_valid;
                    cmd.slot = SLOT_W'(position);
                end
            end
            OP_INSERT_FRONT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    cmd.ins  = req_valid;
                    cmd.slot = '0;
                end
            end
            OP_INSERT_BACK: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    cmd.ins  = req_valid;
                    cmd.slot = SLOT_W'(length);
                end
            end
            OP_READ: begin
                if (pos_at_or_past_end) begin
                    status = ST_RANGE;
                end else begin
                    read_hit = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (pos_at_or_past_end) begin
                    status = ST_RANGE;
                end else begin
                    cmd.rem  = req_valid;
                    cmd.slot = SLOT_W'(position);
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    always_comb begin
        length_next = length;
        if (cmd.ins) begin
            length_next = length + LEN_W'(1);
        end else if (cmd.rem) begin
            length_next = length - LEN_W'(1);
        end
    end

endmodule

### sv/pls_cell.sv
`timescale 1ns / 1ps
// One place of the list: holds a word and takes the new word, its left
// neighbor's word or its right neighbor's word as the command directs.
// Depends on pls_pkg.

module pls_cell
    import pls_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int INDEX      = 0
) (
    input  logic                  aclk,
    input  cell_cmd_t             cmd,
    input  logic [DATA_WIDTH-1:0] word,
    input  logic [DATA_WIDTH-1:0] left_q,
    input  logic [DATA_WIDTH-1:0] right_q,
    output logic [DATA_WIDTH-1:0] q
);

    localparam logic [SLOT_W:0] MY_INDEX = (SLOT_W + 1)'(INDEX);

    logic [DATA_WIDTH-1:0] entry_reg;
    logic [DATA_WIDTH-1:0] entry_next;
    logic [SLOT_W:0]       slot_ext;

    assign slot_ext = {1'b0, cmd.slot};

    always_comb begin
        entry_next = entry_reg;
        if (cmd.ins) begin
            if (MY_INDEX == slot_ext) begin
                entry_next = word;
            end else if (MY_INDEX > slot_ext) begin
                entry_next = left_q;
            end
        end else if (cmd.rem) begin
            if (MY_INDEX >= slot_ext) begin
                entry_next = right_q;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

### sv/positional_list_store.sv
`timescale 1ns / 1ps
// Top level of the positional list store: request decode, the row of cells
// and a two-deep result buffer. Depends on pls_pkg, pls_ctrl and pls_cell.

// The store keeps up to CAPACITY words in list order in a row of cells, one
// word per cell. An insert or a remove shifts every affected cell by one
// place in the same cycle that the request beat is accepted, so the block
// takes one beat per cycle; each result is registered before it reaches the
// master side. The slave side stalls only when both result registers hold
// beats that the master side has not taken. Reads select among the first
// min(CAPACITY, 32) cells through one multiplexer. Cells need no clearing
// after reset: only places below the current count are ever read. Positions
// are five bits wide and the entry count is reported in its low five bits.

module positional_list_store
    import pls_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // s_tdata: func [2:0], position [7:3], payload [39:8].
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // m_tdata: read_data [31:0], status [33:32], empty_flag [34],
    // entry_count [39:35].
    output logic [OUT_W-1:0] m_tdata
);

    localparam int LEN_W     = $clog2(CAPACITY + 1);
    localparam int RD_DEPTH  = (CAPACITY < 32) ? CAPACITY : 32;
    localparam int RD_IDX_W  = $clog2(RD_DEPTH);

    logic [FUNC_W-1:0]     func;
    logic [POS_W-1:0]      position;
    logic [PAYLD_W-1:0]    payload;
    logic [DATA_WIDTH-1:0] word;
    logic                  s_accept;
    logic                  m_pop;

    logic [LEN_W-1:0]      length_reg;
    logic [LEN_W-1:0]      length_next;
    cell_cmd_t             cmd;
    status_t               status;
    logic                  read_hit;

    logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
    logic [DATA_WIDTH-1:0] rd_word;
    result_t               result;

    result_t               out_reg;
    result_t               out_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    result_t               skid_reg;
    result_t               skid_next;
    logic                  skid_valid_reg;
    logic                  skid_valid_next;

    assign func     = s_tdata[FUNC_W-1:0];
    assign position = s_tdata[FUNC_W+POS_W-1:FUNC_W];
    assign payload  = s_tdata[IN_W-1:FUNC_W+POS_W];
    assign word     = DATA_WIDTH'(payload);

    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
    assign m_pop    = out_valid_reg && m_tready;

    pls_ctrl #(
        .CAPACITY (CAPACITY),
        .LEN_W    (LEN_W)
    ) u_ctrl (
        .req_valid   (s_accept),
        .func        (func),
        .position    (position),
        .length      (length_reg),
        .cmd         (cmd),
        .status      (status),
        .read_hit    (read_hit),
        .length_next (length_next)
    );

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_q;
        logic [DATA_WIDTH-1:0] right_q;

        if (i == 0) begin : g_first
            assign left_q = word;
        end else begin : g_left
            assign left_q = cell_q[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_q = cell_q[i];
        end else begin : g_right
            assign right_q = cell_q[i+1];
        end

        pls_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (i)
        ) u_cell (
            .aclk    (aclk),
            .cmd     (cmd),
            .word    (word),
            .left_q  (left_q),
            .right_q (right_q),
            .q       (cell_q[i])
        );
    end

    assign rd_word = cell_q[position[RD_IDX_W-1:0]];

    always_comb begin
        result.read_data   = read_hit ? RDATA_W'(rd_word) : '0;
        result.status      = status;
        result.empty_flag  = (length_next == '0);
        result.entry_count = COUNT_W'(length_next);
    end

    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (m_pop) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = result;
                out_valid_next = s_accept;
            end
        end else if (s_accept) begin
            if (!out_valid_reg) begin
                out_next       = result;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = result;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg     <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                length_reg <= length_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

`ifndef SYNTHESIS
    a_skid_behind_out : assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("Result buffer holds a beat behind an empty output register.");

    a_length_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        length_reg <= LEN_W'(CAPACITY))
        else $error("Entry count exceeds the capacity.");

    a_insert_grows : assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins |=> length_reg == $past(length_reg) + LEN_W'(1))
        else $error("Accepted insert did not grow the list by one entry.");

    a_fail_no_data : assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.status != ST_OK) |-> out_reg.read_data == '0)
        else $error("Failed request returned nonzero read data.");
`endif

endmodule

### verif/list_result_checker.sv
`timescale 1ns / 1ps
// Checker for the positional list store. It watches both stream channels, predicts each
// result beat from its own model of the list, and compares every field. Depends on pls_pkg.

module list_result_checker
    import pls_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,
    output int               mismatch_count,
    output int               pending_count
);

    logic [PAYLD_W-1:0] list_words [CAPACITY];
    int                 list_len;
    result_t            expected_results [$];

    function automatic void shift_in(input int slot, input logic [PAYLD_W-1:0] word);
        for (int i = list_len; i > slot; i--) begin
            list_words[i] = list_words[i-1];
        end
        list_words[slot] = word;
        list_len++;
    endfunction

    function automatic void shift_out(input int slot);
        for (int i = slot; i + 1 < list_len; i++) begin
            list_words[i] = list_words[i+1];
        end
        list_len--;
    endfunction

    function automatic result_t apply_list_op(input logic [FUNC_W-1:0]  op,
                                              input logic [POS_W-1:0]   pos,
                                              input logic [PAYLD_W-1:0] word);
        result_t res;
        res = '0;
        res.status = ST_OK;
        case (op)
            OP_INSERT_AT: begin
                if (pos > list_len) res.status = ST_RANGE;
                else if (list_len >= CAPACITY) res.status = ST_FULL;
                else shift_in(pos, word);
            end
            OP_INSERT_FRONT: begin
                if (list_len >= CAPACITY) res.status = ST_FULL;
                else shift_in(0, word);
            end
            OP_INSERT_BACK: begin
                if (list_len >= CAPACITY) res.status = ST_FULL;
                else shift_in(list_len, word);
            end
            OP_READ: begin
                if (pos >= list_len) res.status = ST_RANGE;
                else res.read_data = list_words[pos];
            end
            OP_REMOVE: begin
                if (pos >= list_len) res.status = ST_RANGE;
                else shift_out(pos);
            end
            default: begin
            end
        endcase
        res.empty_flag  = (list_len == 0);
        res.entry_count = list_len[COUNT_W-1:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (!aresetn) begin
            list_len = 0;
            expected_results.delete();
            mismatch_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata);
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected result beat %h", m_tdata);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (got.read_data !== want.read_data || got.status !== want.status ||
                        got.empty_flag !== want.empty_flag ||
                        got.entry_count !== want.entry_count) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("result mismatch: expected data %h status %0d empty %0d count %0d, got data %h status %0d empty %0d count %0d",
                                     want.read_data, want.status, want.empty_flag,
                                     want.entry_count, got.read_data, got.status,
                                     got.empty_flag, got.entry_count);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_results.push_back(apply_list_op(s_tdata[FUNC_W-1:0],
                                                         s_tdata[FUNC_W +: POS_W],
                                                         s_tdata[FUNC_W+POS_W +: PAYLD_W]));
            end
        end
        pending_count = expected_results.size();
    end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Top of the positional list store testbench: clock, reset, request and result stimulus,
// and the verdict. Depends on pls_pkg, positional_list_store and list_result_checker.

module tb
    import pls_pkg::*;
();

    localparam int CAPACITY        = 16;
    localparam int ITEMS_PER_PHASE = 260;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    int tx_idle_pct   = 29;
    int rx_idle_pct   = 72;
    int stall_cycles  = 0;
    bit stall_request = 1'b0;
    int mismatch_count;
    int pending_count;

    positional_list_store #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (32)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    list_result_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge aclk) begin
        if (stall_request) begin
            stall_request = 1'b0;
            stall_cycles  = 90;
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_cycles > 0) begin
            m_tready <= 1'b0;
            stall_cycles--;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
        end
    end

    task automatic send_beat(input logic [FUNC_W-1:0]  op,
                             input logic [POS_W-1:0]   pos,
                             input logic [PAYLD_W-1:0] word);
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {word, pos, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    task automatic run_directed();
        send_beat(OP_READ, 5'd0, 32'h0);
        send_beat(OP_REMOVE, 5'd0, 32'h0);
        send_beat(OP_INSERT_AT, 5'd1, 32'h1111_1111);
        send_beat(OP_INSERT_AT, 5'd0, 32'h0000_0000);
        send_beat(OP_INSERT_AT, 5'd0, 32'hFFFF_FFFF);
        send_beat(OP_INSERT_FRONT, 5'd9, 32'hA5A5_A5A5);
        send_beat(OP_INSERT_BACK, 5'd31, 32'h5A5A_5A5A);
        send_beat(OP_INSERT_AT, 5'd4, 32'h1234_5678);
        send_beat(OP_READ, 5'd0, 32'h0);
        send_beat(OP_READ, 5'd4, 32'h0);
        send_beat(OP_READ, 5'd5, 32'h0);
        send_beat(OP_REMOVE, 5'd5, 32'h0);
        send_beat(3'd7, 5'd31, 32'hFFFF_FFFF);
        for (int i = 0; i < CAPACITY - 5; i++) begin
            send_beat(OP_INSERT_AT, 5'd2, $urandom);
        end
        send_beat(OP_INSERT_FRONT, 5'd0, 32'hDEAD_BEEF);
        send_beat(OP_INSERT_AT, 5'd16, 32'hCAFE_F00D);
        send_beat(OP_INSERT_AT, 5'd17, 32'h0BAD_0BAD);
        send_beat(OP_REMOVE, 5'd15, 32'h0);
        send_beat(OP_REMOVE, 5'd0, 32'h0);
    endtask

    task automatic send_random(input int count);
        int mode;
        int r;
        int op;
        logic [POS_W-1:0]   pos;
        logic [PAYLD_W-1:0] word;
        int cut [3][5] = '{'{30, 50, 70, 85, 95},
                           '{10, 15, 20, 45, 95},
                           '{22, 32, 42, 70, 95}};
        mode = 2;
        for (int i = 0; i < count; i++) begin
            if (i % 32 == 0) mode = $urandom_range(2, 0);
            if (i == 100) stall_request = 1'b1;
            if (i == 200) wait_drained();
            r  = $urandom_range(99, 0);
            op = 0;
            while (op < 5 && r >= cut[mode][op]) op++;
            if (op == 5) op = $urandom_range(7, 5);
            if ($urandom_range(99, 0) < 80) pos = POS_W'($urandom_range(16, 0));
            else pos = POS_W'($urandom_range(31, 0));
            r = $urandom_range(9, 0);
            if (r == 0) word = '0;
            else if (r == 1) word = '1;
            else word = $urandom;
            send_beat(op[FUNC_W-1:0], pos, word);
        end
    endtask

    initial begin
        int waited;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        run_directed();
        wait_drained();
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 29;
                    rx_idle_pct = 72;
                end
                1: begin
                    tx_idle_pct = 72;
                    rx_idle_pct = 29;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            send_random(ITEMS_PER_PHASE);
        end
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_count != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### sim.f
sv/pls_pkg.sv
sv/pls_ctrl.sv
sv/pls_cell.sv
sv/positional_list_store.sv
verif/list_result_checker.sv
verif/tb.sv
